### design/rnpf_pkg.sv
// Package for the radius neighbor pair finder.
// Holds field widths, default parameters and the controller/datapath interface structs.
// No dependencies.
package rnpf_pkg;

    localparam int COORD_W        = 16;  // Q0.16 coordinate width
    localparam int IDX_OUT_W      = 6;   // index field width on the result stream
    localparam int DIST_W         = 33;  // squared distance / radius width
    localparam int SQ_W           = 2 * COORD_W;
    localparam int IN_TDATA_W     = 32;  // x, y
    localparam int OUT_TDATA_W    = 48;  // older, newer, dist_sq, zero fill
    localparam int DEF_MAX_POINTS = 64;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // capture new point and its index
        logic rd_en;     // read one stored point into the compare pipe
        logic flush_wr;  // release pending pair as last, store new point
        logic ovf;       // emit the overflow result
    } t_dp_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic adv;        // result side can take a result this cycle
        logic pipe_busy;  // compare pipe holds an entry
    } t_dp_stat;

endpackage

### design/rnpf_datapath.sv
// Datapath of the radius neighbor pair finder: point memory, distance pipe,
// pending-pair hold register, result register and radius register.
// Depends on rnpf_pkg.
module rnpf_datapath #(
    parameter int MAX_POINTS = rnpf_pkg::DEF_MAX_POINTS,
    parameter int IDX_W      = $clog2(MAX_POINTS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rnpf_pkg::DIST_W-1:0] i_cfg_data,
    input  logic [rnpf_pkg::COORD_W-1:0] i_x,
    input  logic [rnpf_pkg::COORD_W-1:0] i_y,
    input  logic [IDX_W-1:0]            i_addr,
    input  rnpf_pkg::t_dp_cmd           i_cmd,
    output rnpf_pkg::t_dp_stat          o_stat,
    output logic                        o_m_valid,
    input  logic                        i_m_ready,
    output logic [rnpf_pkg::IDX_OUT_W-1:0] o_older,
    output logic [rnpf_pkg::IDX_OUT_W-1:0] o_newer,
    output logic [rnpf_pkg::DIST_W-1:0] o_dist,
    output logic                        o_last,
    output logic                        o_ovf
);

    localparam int CW = rnpf_pkg::COORD_W;
    localparam int SW = rnpf_pkg::SQ_W;
    localparam int DW = rnpf_pkg::DIST_W;
    localparam int OW = rnpf_pkg::IDX_OUT_W;

    logic [2*CW-1:0] r_mem [MAX_POINTS];
    logic [2*CW-1:0] r_rd;

    logic [DW-1:0]    r_radius;
    logic [CW-1:0]    r_new_x, r_new_y;
    logic [IDX_W-1:0] r_new_idx;

    logic             r_s1_v, r_s2_v, r_s3_v;
    logic [IDX_W-1:0] r_s1_idx, r_s2_idx, r_s3_idx;
    logic [CW-1:0]    r_dx, r_dy;
    logic [SW-1:0]    r_sx, r_sy;

    logic             r_pend_v;
    logic [IDX_W-1:0] r_pend_idx;
    logic [DW-1:0]    r_pend_dist;

    logic             r_out_v;
    logic [OW-1:0]    r_o_older, r_o_newer;
    logic [DW-1:0]    r_o_dist;
    logic             r_o_last, r_o_ovf;

    logic             adv;
    logic [CW-1:0]    rd_x, rd_y, n_dx, n_dy;
    logic [DW-1:0]    sum;
    logic             match;

    assign adv   = !r_out_v || i_m_ready;
    assign rd_x  = r_rd[CW-1:0];
    assign rd_y  = r_rd[2*CW-1:CW];
    assign n_dx  = (r_new_x >= rd_x) ? (r_new_x - rd_x) : (rd_x - r_new_x);
    assign n_dy  = (r_new_y >= rd_y) ? (r_new_y - rd_y) : (rd_y - r_new_y);
    assign sum   = DW'(r_sx) + DW'(r_sy);
    assign match = r_s3_v && (sum <= r_radius);

    assign o_stat.adv       = adv;
    assign o_stat.pipe_busy = r_s1_v || r_s2_v || r_s3_v;

    // point memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.flush_wr) begin
            r_mem[r_new_idx] <= {r_new_y, r_new_x};
        end
        if (adv && i_cmd.rd_en) begin
            r_rd <= r_mem[i_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s3_v   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_data;
            end
            if (adv && (i_cmd.ovf || ((i_cmd.flush_wr || match) && r_pend_v))) begin
                r_out_v <= 1'b1;
            end else if (i_m_ready) begin
                r_out_v <= 1'b0;
            end
            if (adv) begin
                r_s1_v <= i_cmd.rd_en;
                r_s2_v <= r_s1_v;
                r_s3_v <= r_s2_v;
                // a new match replaces the pending pair; the drain releases it
                if (match) begin
                    r_pend_v <= 1'b1;
                end else if (i_cmd.flush_wr) begin
                    r_pend_v <= 1'b0;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new_x   <= i_x;
            r_new_y   <= i_y;
            r_new_idx <= i_addr;
        end
        if (adv) begin
            r_s1_idx <= i_addr;
            r_s2_idx <= r_s1_idx;
            r_s3_idx <= r_s2_idx;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_sx     <= SW'(r_dx * r_dx);
            r_sy     <= SW'(r_dy * r_dy);
            if (i_cmd.ovf) begin
                r_o_older <= '0;
                r_o_newer <= '0;
                r_o_dist  <= '0;
                r_o_last  <= 1'b1;
                r_o_ovf   <= 1'b1;
            end else if ((i_cmd.flush_wr || match) && r_pend_v) begin
                r_o_older <= OW'(r_pend_idx);
                r_o_newer <= OW'(r_new_idx);
                r_o_dist  <= r_pend_dist;
                r_o_last  <= i_cmd.flush_wr;
                r_o_ovf   <= 1'b0;
            end
            if (match) begin
                r_pend_idx  <= r_s3_idx;
                r_pend_dist <= sum;
            end
        end
    end

    assign o_m_valid = r_out_v;
    assign o_older   = r_o_older;
    assign o_newer   = r_o_newer;
    assign o_dist    = r_o_dist;
    assign o_last    = r_o_last;
    assign o_ovf     = r_o_ovf;

endmodule

### design/rnpf_ctrl.sv
// Controller of the radius neighbor pair finder: point count, scan index and
// the sequencing of load, scan, drain/store and overflow.
// Depends on rnpf_pkg.
module rnpf_ctrl #(
    parameter int MAX_POINTS = rnpf_pkg::DEF_MAX_POINTS,
    parameter int IDX_W      = $clog2(MAX_POINTS),
    parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    input  logic               i_new_cloud,
    output logic               o_s_ready,
    input  rnpf_pkg::t_dp_stat i_stat,
    output rnpf_pkg::t_dp_cmd  o_cmd,
    output logic [IDX_W-1:0]   o_addr
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_OVF   = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] cnt_eff;

    assign cnt_eff   = i_new_cloud ? '0 : r_count;
    assign o_s_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_addr  = r_idx[IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_count = cnt_eff;
                    if (cnt_eff >= CNT_W'(MAX_POINTS)) begin
                        n_state = S_OVF;
                    end else begin
                        o_cmd.load = 1'b1;
                        o_addr     = cnt_eff[IDX_W-1:0];
                        n_idx      = '0;
                        n_state    = (cnt_eff == '0) ? S_DRAIN : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.adv) begin
                    o_cmd.rd_en = 1'b1;
                    n_idx       = r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_count) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (i_stat.adv && !i_stat.pipe_busy) begin
                    o_cmd.flush_wr = 1'b1;
                    n_count        = r_count + 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_OVF: begin
                if (i_stat.adv) begin
                    o_cmd.ovf = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    // no compare in flight once back in idle
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_stat.pipe_busy)
        else $error("compare pipe busy in idle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    // reads only touch written entries of the current cloud
    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> (r_idx < r_count))
        else $error("read of unwritten entry");

endmodule

### design/radius_neighbor_pair_finder_unit.sv
// Top level of the radius neighbor pair finder.
// Instantiates rnpf_ctrl and rnpf_datapath; depends on rnpf_pkg.
//
// Each input transaction is one 2-D point (unsigned Q0.16 x and y). The point
// is compared with every point stored for the current cloud, one stored point
// per cycle, and for each one whose squared distance is at most radius_sq a
// result transaction carries (older index, newer index, squared distance), in
// ascending older index, tlast on the final one. A point with no neighbor
// gives no result. tuser on input starts a new cloud (store emptied first).
// A point arriving with the store full is dropped and gives a single result
// with tuser (overflow) and tlast set and all data zero. A new point is
// accepted only once the previous one is through. The single memory read
// port feeds the compare pipe (read, difference, square, add and compare),
// and the final store write follows the scan; the first point of a cloud
// and a dropped point skip the scan. Result back-pressure stalls the pipe.
// radius_sq is written through the cfg channel while the block is idle.
module radius_neighbor_pair_finder_unit #(
    parameter int MAX_POINTS = rnpf_pkg::DEF_MAX_POINTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: radius_sq
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rnpf_pkg::DIST_W-1:0]       i_cfg_data,
    // point stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [rnpf_pkg::IN_TDATA_W-1:0]   i_s_tdata,  // x_coord[15:0], y_coord[31:16]
    input  logic                              i_s_tuser,  // new_cloud
    // pair stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [rnpf_pkg::OUT_TDATA_W-1:0]  o_m_tdata,  // older[5:0], newer[11:6],
                                                          // dist_sq[44:12], zero[47:45]
    output logic                              o_m_tlast,
    output logic                              o_m_tuser   // overflow
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CW    = rnpf_pkg::COORD_W;
    localparam int OW    = rnpf_pkg::IDX_OUT_W;
    localparam int DW    = rnpf_pkg::DIST_W;
    localparam int PAD_W = rnpf_pkg::OUT_TDATA_W - 2 * OW - DW;

    rnpf_pkg::t_dp_cmd  cmd;
    rnpf_pkg::t_dp_stat stat;
    logic [IDX_W-1:0]   addr;
    logic [OW-1:0]      older, newer;
    logic [DW-1:0]      pair_dist;

    // register always takes a write; the user must write it only while the block is idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    rnpf_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (i_s_tvalid),
        .i_new_cloud (i_s_tuser),
        .o_s_ready   (o_s_tready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_addr      (addr)
    );

    rnpf_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_x        (i_s_tdata[CW-1:0]),
        .i_y        (i_s_tdata[2*CW-1:CW]),
        .i_addr     (addr),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_m_valid  (o_m_tvalid),
        .i_m_ready  (i_m_tready),
        .o_older    (older),
        .o_newer    (newer),
        .o_dist     (pair_dist),
        .o_last     (o_m_tlast),
        .o_ovf      (o_m_tuser)
    );

    assign o_m_tdata = {{PAD_W{1'b0}}, pair_dist, newer, older};

endmodule
